### sv/rwa_pkg.sv
// Shared constants, types and codes for the rain window accumulator.
`default_nettype none

package rwa_pkg;

  localparam int CYCLE_SECONDS_DEF = 60;
  localparam int HOURS_KEPT_DEF    = 12;
  localparam int SECONDS_PER_HOUR  = 3600;

  localparam int TIME_W       = 32;
  localparam int PULSE_W      = 16;
  localparam int FACTOR_W     = 16;
  localparam int HOUR_OUT_W   = 22;
  // running sums are exact modulo 2^26, all that the outputs need
  localparam int SUM_W        = 26;
  localparam int CUR_AMT_W    = 32;
  localparam int HOUR_AMT_W   = 38;
  localparam int TWELVE_AMT_W = 42;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int Q_DEPTH = 2;

  typedef logic [PADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_RAIN_FACTOR = reg_idx_t'(0);

  localparam logic [FACTOR_W-1:0] RAIN_FACTOR_RST = 16'd655;
  localparam logic [PULSE_W-1:0]  PULSE_MAX       = '1;

  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // one closed measurement cycle, handed from front to back
  typedef struct packed {
    logic [PULSE_W-1:0] cur_pulses;
    logic               store_hour;
  } cmd_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### sv/rwa_in_if.sv
// Input channel: pulse or time tick items.
`default_nettype none

interface rwa_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [rwa_pkg::TIME_W-1:0]   time_now;

  modport source (output valid, op, time_now, input ready);
  modport sink   (input valid, op, time_now, output ready);
endinterface

`default_nettype wire

### sv/rwa_out_if.sv
// Output channel: rain report items.
`default_nettype none

interface rwa_out_if;
  logic                               valid;
  logic                               ready;
  logic [rwa_pkg::PULSE_W-1:0]        current_pulses;
  logic [rwa_pkg::HOUR_OUT_W-1:0]     hour_pulses;
  logic [rwa_pkg::SUM_W-1:0]          twelve_pulses;
  logic [rwa_pkg::CUR_AMT_W-1:0]      current_amount;
  logic [rwa_pkg::HOUR_AMT_W-1:0]     hour_amount;
  logic [rwa_pkg::TWELVE_AMT_W-1:0]   twelve_amount;

  modport source (output valid, current_pulses, hour_pulses, twelve_pulses,
                  current_amount, hour_amount, twelve_amount, input ready);
  modport sink   (input valid, current_pulses, hour_pulses, twelve_pulses,
                  current_amount, hour_amount, twelve_amount, output ready);
endinterface

`default_nettype wire

### sv/rwa_front.sv
// Front end: pulse counting, cycle and hour timing, command issue.
`default_nettype none

module rwa_front #(
  parameter int CYCLE_SECONDS = rwa_pkg::CYCLE_SECONDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_op,
  input  wire logic [rwa_pkg::TIME_W-1:0]  in_time,
  input  wire rwa_pkg::q_stat_t            q_stat,
  output logic                             push_valid,
  output rwa_pkg::cmd_t                    push_cmd
);

  logic [rwa_pkg::PULSE_W-1:0] pending;
  logic [rwa_pkg::TIME_W-1:0]  next_cycle_time;
  logic [rwa_pkg::TIME_W-1:0]  next_hour_time;
  logic                        accept;
  logic                        is_tick;
  logic                        cycle_due;
  logic                        hour_due;

  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign is_tick   = (in_op == rwa_pkg::OP_TICK);
  assign cycle_due = (in_time >= next_cycle_time);
  assign hour_due  = (in_time >= next_hour_time);

  assign push_valid          = accept && is_tick && cycle_due;
  assign push_cmd.cur_pulses = pending;
  assign push_cmd.store_hour = hour_due;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending         <= '0;
      next_cycle_time <= '0;
      next_hour_time  <= '0;
    end else if (accept) begin
      if (!is_tick) begin
        if (pending != rwa_pkg::PULSE_MAX) begin
          pending <= pending + 1'b1;
        end
      end else if (cycle_due) begin
        pending         <= '0;
        next_cycle_time <= in_time + rwa_pkg::TIME_W'(CYCLE_SECONDS);
        if (hour_due) begin
          next_hour_time <= in_time + rwa_pkg::TIME_W'(rwa_pkg::SECONDS_PER_HOUR);
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/rwa_queue.sv
// Short command queue between front and back.
`default_nettype none

module rwa_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  input  wire rwa_pkg::cmd_t     push_cmd,
  output rwa_pkg::q_stat_t       q_stat,
  output rwa_pkg::cmd_t          pop_cmd,
  input  wire logic              pop
);

  localparam int PTR_W = (rwa_pkg::Q_DEPTH > 1) ? $clog2(rwa_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(rwa_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(rwa_pkg::Q_DEPTH - 1);

  rwa_pkg::cmd_t    entries [rwa_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (count == CNT_W'(rwa_pkg::Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_cmd      = entries[rd_ptr];
  assign do_push      = push_valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/rwa_back.sv
// Back end: hour and twelve-hour rings, running sums, scaling, output register.
`default_nettype none

module rwa_back #(
  parameter int SLOTS      = rwa_pkg::SECONDS_PER_HOUR / rwa_pkg::CYCLE_SECONDS_DEF,
  parameter int HOURS_KEPT = rwa_pkg::HOURS_KEPT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rwa_pkg::q_stat_t              q_stat,
  input  wire rwa_pkg::cmd_t                 cmd,
  output logic                               pop,
  input  wire logic [rwa_pkg::FACTOR_W-1:0]  rain_factor,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rwa_pkg::PULSE_W-1:0]        current_pulses,
  output logic [rwa_pkg::HOUR_OUT_W-1:0]     hour_pulses,
  output logic [rwa_pkg::SUM_W-1:0]          twelve_pulses,
  output logic [rwa_pkg::CUR_AMT_W-1:0]      current_amount,
  output logic [rwa_pkg::HOUR_AMT_W-1:0]     hour_amount,
  output logic [rwa_pkg::TWELVE_AMT_W-1:0]   twelve_amount
);

  localparam int HS_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TS_W = (HOURS_KEPT > 1) ? $clog2(HOURS_KEPT) : 1;
  localparam logic [HS_W-1:0] HOUR_LAST   = HS_W'(SLOTS - 1);
  localparam logic [TS_W-1:0] TWELVE_LAST = TS_W'(HOURS_KEPT - 1);
  localparam int SW = rwa_pkg::SUM_W;

  // hour ring
  logic [rwa_pkg::PULSE_W-1:0] hour_mem [SLOTS];
  logic [rwa_pkg::PULSE_W-1:0] hour_rd;
  logic [HS_W-1:0]             hour_slot;
  logic [HS_W-1:0]             hour_slot_next;
  logic                        hour_wrapped;
  logic [SW-1:0]               hour_total;
  logic [SW-1:0]               hour_old;
  logic [SW-1:0]               hour_new;

  // twelve-hour ring
  logic [SW-1:0]               twelve_mem [HOURS_KEPT];
  logic [SW-1:0]               twelve_rd;
  logic [TS_W-1:0]             twelve_slot;
  logic [TS_W-1:0]             twelve_slot_next;
  logic                        twelve_wrapped;
  logic [SW-1:0]               twelve_total;
  logic [SW-1:0]               twelve_old;
  logic [SW-1:0]               twelve_new;
  logic [SW-1:0]               twelve_sum;
  logic                        do_store;

  // sum stage
  logic                        b_valid;
  logic [rwa_pkg::PULSE_W-1:0] b_cur;
  logic [SW-1:0]               b_hour;
  logic [SW-1:0]               b_twelve;

  logic fire_a;
  logic load_c;
  logic b_ready;
  logic c_ready;

  assign c_ready = !out_valid || out_ready;
  assign b_ready = !b_valid || c_ready;
  assign fire_a  = !q_stat.empty && b_ready;
  assign pop     = fire_a;
  assign load_c  = b_valid && c_ready;

  // an entry not yet written since reset reads as zero
  assign hour_old   = hour_wrapped ? SW'(hour_rd) : '0;
  assign hour_new   = hour_total - hour_old + SW'(cmd.cur_pulses);
  assign twelve_old = twelve_wrapped ? twelve_rd : '0;
  assign twelve_sum = twelve_total + hour_new;
  assign twelve_new = twelve_total - twelve_old + hour_new;
  assign do_store   = fire_a && cmd.store_hour;

  always_comb begin
    hour_slot_next = hour_slot;
    if (fire_a) begin
      hour_slot_next = (hour_slot == HOUR_LAST) ? '0 : hour_slot + 1'b1;
    end
  end

  always_comb begin
    twelve_slot_next = twelve_slot;
    if (do_store) begin
      twelve_slot_next = (twelve_slot == TWELVE_LAST) ? '0 : twelve_slot + 1'b1;
    end
  end

  // ring memories: write the slot being closed, read ahead at the next slot
  always_ff @(posedge clk) begin
    if (fire_a) begin
      hour_mem[hour_slot] <= cmd.cur_pulses;
    end
    if (fire_a && (hour_slot_next == hour_slot)) begin
      hour_rd <= cmd.cur_pulses;
    end else begin
      hour_rd <= hour_mem[hour_slot_next];
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      twelve_mem[twelve_slot] <= hour_new;
    end
    if (do_store && (twelve_slot_next == twelve_slot)) begin
      twelve_rd <= hour_new;
    end else begin
      twelve_rd <= twelve_mem[twelve_slot_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_slot      <= '0;
      hour_wrapped   <= 1'b0;
      hour_total     <= '0;
      twelve_slot    <= '0;
      twelve_wrapped <= 1'b0;
      twelve_total   <= '0;
      b_valid        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      hour_slot   <= hour_slot_next;
      twelve_slot <= twelve_slot_next;
      if (fire_a) begin
        hour_total <= hour_new;
        if (hour_slot == HOUR_LAST) begin
          hour_wrapped <= 1'b1;
        end
      end
      if (do_store) begin
        twelve_total <= twelve_new;
        if (twelve_slot == TWELVE_LAST) begin
          twelve_wrapped <= 1'b1;
        end
      end
      b_valid   <= fire_a || (b_valid && !c_ready);
      out_valid <= load_c || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (fire_a) begin
      b_cur    <= cmd.cur_pulses;
      b_hour   <= hour_new;
      b_twelve <= twelve_sum;
    end
  end

  // scaling by the rain factor; products keep 16 fraction bits
  always_ff @(posedge clk) begin
    if (load_c) begin
      current_pulses <= b_cur;
      hour_pulses    <= b_hour[rwa_pkg::HOUR_OUT_W-1:0];
      twelve_pulses  <= b_twelve;
      current_amount <= rwa_pkg::CUR_AMT_W'(b_cur) * rwa_pkg::CUR_AMT_W'(rain_factor);
      hour_amount    <= rwa_pkg::HOUR_AMT_W'(b_hour[rwa_pkg::HOUR_OUT_W-1:0])
                        * rwa_pkg::HOUR_AMT_W'(rain_factor);
      twelve_amount  <= rwa_pkg::TWELVE_AMT_W'(b_twelve)
                        * rwa_pkg::TWELVE_AMT_W'(rain_factor);
    end
  end

endmodule

`default_nettype wire

### sv/rain_window_accumulator.sv
// Rain window accumulator: tipping-bucket pulse counter with hour and
// twelve-hour running sums. Each input item is either one pulse (op 0)
// or a time tick carrying the current time in seconds (op 1). Pulses
// saturate at 65535. A tick at or past the next cycle time closes the
// cycle: its count goes into the hour ring (3600/CYCLE_SECONDS slots)
// and one report item comes out with the current, rolling-hour and
// twelve-hour pulse counts and the same three scaled by rain_factor
// (16 fraction bits). When the tick is also at or past the next hour
// time, the rolling-hour total is stored in the HOURS_KEPT-deep ring
// after the report figures are formed. A tick before the cycle time and
// a pulse give no report. Times compare as plain unsigned 32-bit values
// and the next times wrap modulo 2^32.
// Throughput is one item per clock, pulses and ticks alike, with the
// queue and output register absorbing short output stalls; the pace is
// set by the hour ring memory, which takes one write and one look-ahead
// read per clock. A report passes from the closing tick through the
// queue, the ring update stage and the multiply and output register.
// No clearing pass follows reset: ring slots not yet written since
// reset read as zero. rain_factor sits at APB byte address 0, resets
// to 655 and should only be written while no report is pending.
`default_nettype none

module rain_window_accumulator #(
  parameter int CYCLE_SECONDS = rwa_pkg::CYCLE_SECONDS_DEF,
  parameter int HOURS_KEPT    = rwa_pkg::HOURS_KEPT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  rwa_in_if.sink                             item_in,
  rwa_out_if.source                          result_out,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rwa_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [rwa_pkg::PDATA_W-1:0]   pwdata,
  output logic [rwa_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int SLOTS = rwa_pkg::SECONDS_PER_HOUR / CYCLE_SECONDS;

  logic [rwa_pkg::FACTOR_W-1:0] rain_factor;
  rwa_pkg::reg_idx_t            reg_idx;
  logic                         cfg_write;

  rwa_pkg::q_stat_t q_stat;
  rwa_pkg::cmd_t    push_cmd;
  rwa_pkg::cmd_t    pop_cmd;
  logic             push_valid;
  logic             pop;

  // APB register: single word, zero wait states
  assign pready    = 1'b1;
  assign reg_idx   = paddr[rwa_pkg::PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rain_factor <= rwa_pkg::RAIN_FACTOR_RST;
    end else if (cfg_write && (reg_idx == rwa_pkg::REG_RAIN_FACTOR)) begin
      rain_factor <= pwdata[rwa_pkg::FACTOR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == rwa_pkg::REG_RAIN_FACTOR) begin
      prdata = rwa_pkg::PDATA_W'(rain_factor);
    end
  end

  // front: counts pulses, decides which ticks close a cycle or an hour
  rwa_front #(
    .CYCLE_SECONDS (CYCLE_SECONDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item_in.valid),
    .in_ready   (item_in.ready),
    .in_op      (item_in.op),
    .in_time    (item_in.time_now),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  rwa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_stat     (q_stat),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  // back: ring updates, running totals, scaling and report register
  rwa_back #(
    .SLOTS      (SLOTS),
    .HOURS_KEPT (HOURS_KEPT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .cmd            (pop_cmd),
    .pop            (pop),
    .rain_factor    (rain_factor),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .current_pulses (result_out.current_pulses),
    .hour_pulses    (result_out.hour_pulses),
    .twelve_pulses  (result_out.twelve_pulses),
    .current_amount (result_out.current_amount),
    .hour_amount    (result_out.hour_amount),
    .twelve_amount  (result_out.twelve_amount)
  );

endmodule

`default_nettype wire

### sv/rwa_chk.sv
// Port-level checks for the rain window accumulator, bound to the top level.
`default_nettype none

module rwa_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rwa_pkg::PULSE_W-1:0]   current_pulses,
  input wire logic [rwa_pkg::CUR_AMT_W-1:0] current_amount,
  input wire logic [rwa_pkg::HOUR_OUT_W-1:0] hour_pulses,
  input wire logic [rwa_pkg::HOUR_AMT_W-1:0] hour_amount,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic                          pready,
  input wire logic [rwa_pkg::PADDR_W-1:0]   paddr,
  input wire logic [rwa_pkg::PDATA_W-1:0]   pwdata,
  input wire logic [rwa_pkg::PDATA_W-1:0]   prdata
);

  logic wr_factor;
  logic rd_factor;

  assign wr_factor = psel && penable && pwrite && pready
                     && (paddr[rwa_pkg::PADDR_W-1:2] == rwa_pkg::REG_RAIN_FACTOR);
  assign rd_factor = (paddr[rwa_pkg::PADDR_W-1:2] == rwa_pkg::REG_RAIN_FACTOR);

  // a stalled report stays valid and its current pulses and amount hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_pulses)
                               && $stable(current_amount))
    else $error("report changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("report valid right after reset");

  a_zero_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (current_pulses != '0 || current_amount == '0)
                  && (hour_pulses != '0 || hour_amount == '0))
    else $error("zero pulses scaled to a non-zero amount");

  a_factor_readback: assert property (@(posedge clk) disable iff (rst)
    wr_factor |=> !rd_factor
                  || prdata == rwa_pkg::PDATA_W'($past(pwdata[rwa_pkg::FACTOR_W-1:0])))
    else $error("rain factor readback mismatch");

endmodule

bind rain_window_accumulator rwa_chk u_rwa_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .current_pulses (result_out.current_pulses),
  .current_amount (result_out.current_amount),
  .hour_pulses    (result_out.hour_pulses),
  .hour_amount    (result_out.hour_amount),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .pready         (pready),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

`default_nettype wire
